### sv/limit_order_book_matcher_macros.svh
// Assertion macros used by the order book top level.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define LOB_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LOB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/lob_pkg.sv
// Package: defaults, request codes, status codes and sequencer phases of the order book.
package lob_pkg;

    localparam int ORDER_SLOTS_DEF = 64;
    localparam int PRICE_BITS_DEF  = 32;
    localparam int QTY_BITS_DEF    = 32;
    localparam int ARRIVAL_BITS    = 32;
    localparam int ID_BITS         = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_RESTED    = 3'd1,
        ST_FILLED    = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_BOOK_FULL = 3'd5,
        ST_DUP_ID    = 3'd6,
        ST_ZERO_QTY  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PH_LOOKUP = 2'd0,
        PH_MATCH  = 2'd1,
        PH_FINAL  = 2'd2
    } t_phase;

endpackage

### sv/limit_order_book_matcher.sv
// Top level: single-symbol price-time priority order book with its sequencer.
//
// Input channel (i_valid / o_ready): one request per transfer, op add, cancel or
// modify with id, side, price and quantity. o_ready is high only while the block
// holds no request. Output channel (o_valid / i_ready): one item per fill, the
// last of which also carries the request's status with best bid and ask and is
// marked o_last; a request without fills gives a single status-only item.
// Every pass over the book runs a token down the row of ORDER_SLOTS slot cells,
// one cell per cycle, finding the id, the best crossing opposite order, the
// lowest free slot and the best prices in one go; each pass ends in a decision
// step. A request takes a lookup pass and one more pass after each decision that
// fills, removes or rests an order or finds the book full; requests rejected at
// lookup take one pass.
// Reset clears all slots, the arrival counter and both channels at once.
// A stalled receiver holds the sequencer at its next decision or closing step; the book
// is left unchanged until the output register is free.
`include "limit_order_book_matcher_macros.svh"

module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS    = lob_pkg::QTY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_trade,
    output logic [31:0] o_buy_order_id,
    output logic [31:0] o_sell_order_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_quantity,
    output logic [2:0]  o_status,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic        o_last
);

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int DW = lob_pkg::ID_BITS;
    localparam int AW = lob_pkg::ARRIVAL_BITS;

    typedef struct packed {
        logic                  vld;
        logic                  id_hit;
        logic [IW-1:0]         id_idx;
        logic                  id_side;
        logic                  free_hit;
        logic [IW-1:0]         free_idx;
        logic                  best_hit;
        logic [IW-1:0]         best_idx;
        logic [DW-1:0]         best_id;
        logic [PRICE_BITS-1:0] best_price;
        logic [QTY_BITS-1:0]   best_rem;
        logic [AW-1:0]         best_age;
        logic [PRICE_BITS-1:0] bid;
        logic                  ask_hit;
        logic [PRICE_BITS-1:0] ask;
    } t_carry;

    typedef struct packed {
        logic                  kill;
        logic                  sub;
        logic                  wr;
        logic [IW-1:0]         idx;
        logic [QTY_BITS-1:0]   amt;
        logic [DW-1:0]         id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [AW-1:0]         cnt;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_LAST   = 5'b10000
    } t_state;

    t_state                r_state;
    lob_pkg::t_phase       r_phase;
    lob_pkg::t_op          r_op;
    lob_pkg::t_status      r_status;
    logic [DW-1:0]         r_id;
    logic                  r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;
    logic [AW-1:0]         r_cnt;
    t_carry                r_res;

    logic                  r_pend_vld;
    logic [DW-1:0]         r_pend_buy;
    logic [DW-1:0]         r_pend_sell;
    logic [PRICE_BITS-1:0] r_pend_price;
    logic [QTY_BITS-1:0]   r_pend_qty;

    logic                  r_o_valid;
    logic                  r_o_is_trade;
    logic [31:0]           r_o_buy;
    logic [31:0]           r_o_sell;
    logic [31:0]           r_o_price;
    logic [31:0]           r_o_qty;
    lob_pkg::t_status      r_o_status;
    logic [31:0]           r_o_bid;
    logic [31:0]           r_o_ask;
    logic                  r_o_last;

    t_carry                w_head;
    t_carry                w_carry [0:ORDER_SLOTS];
    logic [ORDER_SLOTS:0]  w_tok;
    t_cmd                  w_cmd;
    logic                  w_out_free;
    logic                  w_accept;
    logic [QTY_BITS-1:0]   w_fill;
    logic                  w_match;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_fill     = (r_qty < r_res.best_rem) ? r_qty : r_res.best_rem;
    // Decision cycle that runs one matching step against the pass result.
    assign w_match    = (r_phase == lob_pkg::PH_MATCH) ||
                        (r_phase == lob_pkg::PH_LOOKUP && r_op == lob_pkg::OP_ADD &&
                         r_qty != '0 && !r_res.id_hit);

    always_comb begin
        w_head     = '0;
        w_head.vld = (r_state == S_START);
    end

    assign w_carry[0] = w_head;

    always_comb begin
        w_cmd       = '0;
        w_cmd.id    = r_id;
        w_cmd.side  = r_side;
        w_cmd.price = r_price;
        w_cmd.cnt   = r_cnt;
        w_cmd.amt   = r_qty;
        if (r_state == S_DECIDE && w_out_free) begin
            if (r_phase == lob_pkg::PH_LOOKUP && r_res.id_hit &&
                (r_op == lob_pkg::OP_CANCEL || r_op == lob_pkg::OP_MODIFY)) begin
                w_cmd.kill = 1'b1;
                w_cmd.idx  = r_res.id_idx;
            end else if (w_match && r_res.best_hit) begin
                w_cmd.sub = 1'b1;
                w_cmd.idx = r_res.best_idx;
                w_cmd.amt = w_fill;
            end else if (w_match && r_res.free_hit) begin
                w_cmd.wr  = 1'b1;
                w_cmd.idx = r_res.free_idx;
            end
        end
    end

    for (genvar gi = 0; gi < ORDER_SLOTS; gi++) begin : g_cell
        lob_cell #(
            .t_carry    (t_carry),
            .t_cmd      (t_cmd),
            .IDX        (gi),
            .IDX_BITS   (IW),
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_carry (w_carry[gi]),
            .o_carry (w_carry[gi+1])
        );
    end

    for (genvar gt = 0; gt <= ORDER_SLOTS; gt++) begin : g_tok
        assign w_tok[gt] = w_carry[gt].vld;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= lob_pkg::PH_LOOKUP;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase    <= lob_pkg::PH_LOOKUP;
                        r_pend_vld <= 1'b0;
                        r_state    <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_carry[ORDER_SLOTS].vld) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        if (r_phase == lob_pkg::PH_FINAL) begin
                            r_state <= S_LAST;
                        end else if (w_match) begin
                            r_state <= S_START;
                            if (r_res.best_hit) begin
                                r_pend_vld <= 1'b1;
                                if (r_qty == w_fill) begin
                                    r_phase <= lob_pkg::PH_FINAL;
                                end else begin
                                    r_phase <= lob_pkg::PH_MATCH;
                                end
                            end else begin
                                r_phase <= lob_pkg::PH_FINAL;
                                if (r_res.free_hit) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                        end else if ((r_op == lob_pkg::OP_CANCEL ||
                                      r_op == lob_pkg::OP_MODIFY) && r_res.id_hit) begin
                            r_state <= S_START;
                            if (r_op == lob_pkg::OP_CANCEL || r_qty == '0) begin
                                r_phase <= lob_pkg::PH_FINAL;
                            end else begin
                                r_phase <= lob_pkg::PH_MATCH;
                            end
                        end else begin
                            r_state <= S_LAST;
                        end
                    end
                end
                S_LAST: begin
                    if (w_out_free) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload, pass result, status and held trade
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= lob_pkg::t_op'(i_op);
            r_id     <= i_order_id;
            r_side   <= i_side;
            r_price  <= PRICE_BITS'(i_price);
            r_qty    <= QTY_BITS'(i_quantity);
            r_status <= lob_pkg::ST_NONE;
        end
        if (r_state == S_SCAN && w_carry[ORDER_SLOTS].vld) begin
            r_res <= w_carry[ORDER_SLOTS];
        end
        if (r_state == S_DECIDE && w_out_free && r_phase != lob_pkg::PH_FINAL) begin
            if (w_match) begin
                if (r_res.best_hit) begin
                    r_qty        <= r_qty - w_fill;
                    r_pend_buy   <= r_side ? r_res.best_id : r_id;
                    r_pend_sell  <= r_side ? r_id : r_res.best_id;
                    r_pend_price <= r_res.best_price;
                    r_pend_qty   <= w_fill;
                    if (r_qty == w_fill) begin
                        r_status <= lob_pkg::ST_FILLED;
                    end
                end else if (r_res.free_hit) begin
                    r_status <= lob_pkg::ST_RESTED;
                end else begin
                    r_status <= lob_pkg::ST_BOOK_FULL;
                end
            end else if (r_op == lob_pkg::OP_ADD) begin
                r_status <= (r_qty == '0) ? lob_pkg::ST_ZERO_QTY : lob_pkg::ST_DUP_ID;
            end else if (r_op == lob_pkg::OP_CANCEL || r_op == lob_pkg::OP_MODIFY) begin
                if (!r_res.id_hit) begin
                    r_status <= lob_pkg::ST_NOT_FOUND;
                end else if (r_op == lob_pkg::OP_CANCEL || r_qty == '0) begin
                    r_status <= lob_pkg::ST_CANCELLED;
                end else begin
                    r_side <= r_res.id_side;
                end
            end else begin
                r_status <= lob_pkg::ST_NONE;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_LAST && w_out_free) ||
                     (r_state == S_DECIDE && w_out_free && w_match &&
                      r_res.best_hit && r_pend_vld)) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && w_out_free && w_match && r_res.best_hit && r_pend_vld) begin
            r_o_is_trade <= 1'b1;
            r_o_buy      <= r_pend_buy;
            r_o_sell     <= r_pend_sell;
            r_o_price    <= 32'(r_pend_price);
            r_o_qty      <= 32'(r_pend_qty);
            r_o_status   <= lob_pkg::ST_NONE;
            r_o_bid      <= '0;
            r_o_ask      <= '0;
            r_o_last     <= 1'b0;
        end else if (r_state == S_LAST && w_out_free) begin
            r_o_is_trade <= r_pend_vld;
            r_o_buy      <= r_pend_vld ? r_pend_buy : '0;
            r_o_sell     <= r_pend_vld ? r_pend_sell : '0;
            r_o_price    <= r_pend_vld ? 32'(r_pend_price) : '0;
            r_o_qty      <= r_pend_vld ? 32'(r_pend_qty) : '0;
            r_o_status   <= r_status;
            r_o_bid      <= 32'(r_res.bid);
            r_o_ask      <= r_res.ask_hit ? 32'(r_res.ask) : '0;
            r_o_last     <= 1'b1;
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_is_trade       = r_o_is_trade;
    assign o_buy_order_id   = r_o_buy;
    assign o_sell_order_id  = r_o_sell;
    assign o_trade_price    = r_o_price;
    assign o_trade_quantity = r_o_qty;
    assign o_status         = r_o_status;
    assign o_best_bid       = r_o_bid;
    assign o_best_ask       = r_o_ask;
    assign o_last           = r_o_last;

    `LOB_ASSERT_ALWAYS(a_one_token, $countones(w_tok) <= 1, "two scan tokens in the row")
    `LOB_ASSERT_ALWAYS(a_one_cmd, $onehot0({w_cmd.kill, w_cmd.sub, w_cmd.wr}), "cmd clash")
    `LOB_ASSERT_IMPLIES(a_tail_scan, w_carry[ORDER_SLOTS].vld, r_state == S_SCAN, "stray token")
    `LOB_ASSERT_IMPLIES(a_fill_nz, w_cmd.sub, w_cmd.amt != '0, "zero-size fill issued")

endmodule

### sv/lob_cell.sv
// One order slot of the book plus its stage of the scan chain.
module lob_cell #(
    parameter type t_carry    = logic,
    parameter type t_cmd      = logic,
    parameter int  IDX        = 0,
    parameter int  IDX_BITS   = 6,
    parameter int  PRICE_BITS = lob_pkg::PRICE_BITS_DEF,
    parameter int  QTY_BITS   = lob_pkg::QTY_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_carry i_carry,
    output t_carry o_carry
);

    logic                               r_valid;
    logic [lob_pkg::ID_BITS-1:0]        r_id;
    logic                               r_side;
    logic [PRICE_BITS-1:0]              r_price;
    logic [QTY_BITS-1:0]                r_rem;
    logic [lob_pkg::ARRIVAL_BITS-1:0]   r_arr;
    t_carry                             r_carry;
    t_carry                             n_carry;

    logic                               w_sel;
    logic                               w_cross;
    logic                               w_better;
    logic [lob_pkg::ARRIVAL_BITS-1:0]   w_age;

    assign w_sel = (i_cmd.idx == IDX_BITS'(IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            if (i_cmd.kill) begin
                r_valid <= 1'b0;
            end else if (i_cmd.sub) begin
                if (r_rem == i_cmd.amt) begin
                    r_valid <= 1'b0;
                end
            end else if (i_cmd.wr) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_cmd.sub) begin
            r_rem <= r_rem - i_cmd.amt;
        end else if (w_sel && i_cmd.wr) begin
            r_id    <= i_cmd.id;
            r_side  <= i_cmd.side;
            r_price <= i_cmd.price;
            r_rem   <= i_cmd.amt;
            r_arr   <= i_cmd.cnt;
        end
    end

    // Price crosses the incoming limit; earlier arrival means larger age.
    assign w_cross = (i_cmd.side == 1'b0) ? (r_price <= i_cmd.price)
                                          : (r_price >= i_cmd.price);
    assign w_age   = i_cmd.cnt - r_arr;

    always_comb begin
        if (!i_carry.best_hit) begin
            w_better = 1'b1;
        end else if (r_price != i_carry.best_price) begin
            w_better = (i_cmd.side == 1'b0) ? (r_price < i_carry.best_price)
                                            : (r_price > i_carry.best_price);
        end else begin
            w_better = w_age > i_carry.best_age;
        end
    end

    always_comb begin
        n_carry = i_carry;
        if (r_valid && !i_carry.id_hit && r_id == i_cmd.id) begin
            n_carry.id_hit  = 1'b1;
            n_carry.id_idx  = IDX_BITS'(IDX);
            n_carry.id_side = r_side;
        end
        if (!r_valid && !i_carry.free_hit) begin
            n_carry.free_hit = 1'b1;
            n_carry.free_idx = IDX_BITS'(IDX);
        end
        if (r_valid && r_side != i_cmd.side && w_cross && w_better) begin
            n_carry.best_hit   = 1'b1;
            n_carry.best_idx   = IDX_BITS'(IDX);
            n_carry.best_id    = r_id;
            n_carry.best_price = r_price;
            n_carry.best_rem   = r_rem;
            n_carry.best_age   = w_age;
        end
        if (r_valid && r_side == 1'b0 && r_price > i_carry.bid) begin
            n_carry.bid = r_price;
        end
        if (r_valid && r_side == 1'b1 && (!i_carry.ask_hit || r_price < i_carry.ask)) begin
            n_carry.ask_hit = 1'b1;
            n_carry.ask     = r_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.vld <= 1'b0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule

### verif/limit_order_book_matcher_checker.sv
// Checker: watches both channels, predicts book results and compares them.
`timescale 1ns / 1ps

module limit_order_book_matcher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic        i_is_trade,
    input  logic [31:0] i_buy_order_id,
    input  logic [31:0] i_sell_order_id,
    input  logic [31:0] i_trade_price,
    input  logic [31:0] i_trade_quantity,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_best_bid,
    input  logic [31:0] i_best_ask,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    localparam int SLOTS = 64;

    typedef struct packed {
        logic        is_trade;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [31:0] px;
        logic [31:0] qty;
        logic [2:0]  status;
        logic [31:0] bid;
        logic [31:0] ask;
        logic        last;
    } t_book_item;

    logic        live   [SLOTS];
    logic [31:0] oid    [SLOTS];
    logic        oside  [SLOTS];
    logic [31:0] oprice [SLOTS];
    logic [31:0] orem   [SLOTS];
    logic [31:0] oarr   [SLOTS];
    logic [31:0] arrivals;
    t_book_item  fills_due[$];

    function automatic int lookup_id(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && oid[i] == id) return i;
        return -1;
    endfunction

    function automatic lob_pkg::t_status match_order(logic [31:0] id, logic sd,
                                                     logic [31:0] px, logic [31:0] q,
                                                     ref t_book_item fl[$]);
        int best, slot;
        logic [31:0] age, best_age, f;
        logic better;
        t_book_item it;
        best_age = '0;
        if (q == 0) return lob_pkg::ST_ZERO_QTY;
        if (lookup_id(id) >= 0) return lob_pkg::ST_DUP_ID;
        while (q > 0 && fl.size() < SLOTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i] || oside[i] == sd) continue;
                if (sd == 1'b0 ? oprice[i] > px : oprice[i] < px) continue;
                age = arrivals - oarr[i];
                if (best < 0) better = 1'b1;
                else if (oprice[i] != oprice[best])
                    better = (sd == 1'b0) ? oprice[i] < oprice[best] : oprice[i] > oprice[best];
                else better = age > best_age;
                if (better) begin
                    best = i;
                    best_age = age;
                end
            end
            if (best < 0) break;
            f = (q < orem[best]) ? q : orem[best];
            it = '0;
            it.is_trade = 1'b1;
            it.buy_id  = sd ? oid[best] : id;
            it.sell_id = sd ? id : oid[best];
            it.px  = oprice[best];
            it.qty = f;
            fl = {fl, it};
            q = q - f;
            orem[best] = orem[best] - f;
            if (orem[best] == 0) live[best] = 1'b0;
        end
        if (q == 0) return lob_pkg::ST_FILLED;
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!live[i]) begin
                slot = i;
                break;
            end
        if (slot < 0) return lob_pkg::ST_BOOK_FULL;
        live[slot] = 1'b1;
        oid[slot] = id;
        oside[slot] = sd;
        oprice[slot] = px;
        orem[slot] = q;
        oarr[slot] = arrivals;
        arrivals = arrivals + 1;
        return lob_pkg::ST_RESTED;
    endfunction

    task automatic predict_request(logic [1:0] op, logic [31:0] id, logic sd,
                                   logic [31:0] px, logic [31:0] q);
        t_book_item fl[$];
        t_book_item it;
        lob_pkg::t_status st;
        logic [31:0] bid, ask;
        logic hb, ha;
        int k;
        st = lob_pkg::ST_NONE;
        bid = '0;
        ask = '0;
        hb = 1'b0;
        ha = 1'b0;
        if (op == lob_pkg::OP_ADD) st = match_order(id, sd, px, q, fl);
        else if (op == lob_pkg::OP_CANCEL || op == lob_pkg::OP_MODIFY) begin
            k = lookup_id(id);
            if (k < 0) st = lob_pkg::ST_NOT_FOUND;
            else begin
                live[k] = 1'b0;
                if (op == lob_pkg::OP_CANCEL || q == 0) st = lob_pkg::ST_CANCELLED;
                else st = match_order(id, oside[k], px, q, fl);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!live[i]) continue;
            if (oside[i] == 1'b0) begin
                if (!hb || oprice[i] > bid) bid = oprice[i];
                hb = 1'b1;
            end else begin
                if (!ha || oprice[i] < ask) ask = oprice[i];
                ha = 1'b1;
            end
        end
        if (fl.size() == 0) begin
            it = '0;
            fl = {fl, it};
        end
        it = fl[$];
        it.status = st;
        it.bid = bid;
        it.ask = ask;
        it.last = 1'b1;
        fl[fl.size() - 1] = it;
        fills_due = {fills_due, fl};
    endtask

    always @(posedge i_clk) begin
        t_book_item got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
            arrivals = '0;
            fills_due.delete();
            o_errors <= 0;
        end else begin
            if (i_valid_out && i_ready) begin
                got = {i_is_trade, i_buy_order_id, i_sell_order_id, i_trade_price,
                       i_trade_quantity, i_status, i_best_bid, i_best_ask, i_last};
                if (fills_due.size() == 0) begin
                    $display("%0t: unexpected result, got %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = fills_due.pop_front();
                    if (got != want) begin
                        $display({"%0t: mismatch expected trade=%b buy=%h sell=%h px=%h",
                                  " q=%h st=%0d bid=%h ask=%h last=%b"},
                                 $time, want.is_trade, want.buy_id, want.sell_id, want.px,
                                 want.qty, want.status, want.bid, want.ask, want.last);
                        $display({"%0t:          actual   trade=%b buy=%h sell=%h px=%h",
                                  " q=%h st=%0d bid=%h ask=%h last=%b"},
                                 $time, got.is_trade, got.buy_id, got.sell_id, got.px,
                                 got.qty, got.status, got.bid, got.ask, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // predict after the pop so a same-edge request cannot confuse ordering
            if (i_valid && i_ready_in)
                predict_request(i_op, i_order_id, i_side, i_price, i_quantity);
        end
        o_pending <= fills_due.size();
    end
endmodule

### verif/limit_order_book_matcher_tb.sv
// Testbench top: drives order requests, stalls the receiver and reports the verdict.
`timescale 1ns / 1ps

module limit_order_book_matcher_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = lob_pkg::OP_ADD;
    logic [31:0] order_id = '0;
    logic        side = 1'b0;
    logic [31:0] price = '0;
    logic [31:0] quantity = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_trade, last;
    logic [31:0] buy_id, sell_id, trade_px, trade_qty, best_bid, best_ask;
    logic [2:0]  status;
    int          errors, pending;
    int          cycles = 0;
    int          stall_mode = 0;
    logic [31:0] used_ids[$];

    localparam int CYCLE_LIMIT = 20000000;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    limit_order_book_matcher uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_op(op), .i_order_id(order_id), .i_side(side), .i_price(price),
        .i_quantity(quantity), .o_valid(out_valid), .i_ready(out_ready),
        .o_is_trade(is_trade), .o_buy_order_id(buy_id), .o_sell_order_id(sell_id),
        .o_trade_price(trade_px), .o_trade_quantity(trade_qty), .o_status(status),
        .o_best_bid(best_bid), .o_best_ask(best_ask), .o_last(last)
    );

    limit_order_book_matcher_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_op(op), .i_order_id(order_id), .i_side(side), .i_price(price),
        .i_quantity(quantity), .i_valid_out(out_valid), .i_ready(out_ready),
        .i_is_trade(is_trade), .i_buy_order_id(buy_id), .i_sell_order_id(sell_id),
        .i_trade_price(trade_px), .i_trade_quantity(trade_qty), .i_status(status),
        .i_best_bid(best_bid), .i_best_ask(best_ask), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: modes switch every so often
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cycles % 7) < 3;
        endcase
        if (cycles > CYCLE_LIMIT) begin
            $display("limit_order_book_matcher test failed");
            $finish;
        end
    end

    // valid stays high after the transfer; the caller drops it at a gap
    task automatic send(logic [1:0] o, logic [31:0] id, logic s, logic [31:0] p,
                        logic [31:0] q);
        in_valid <= 1'b1;
        op <= o;
        order_id <= id;
        side <= s;
        price <= p;
        quantity <= q;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (o == lob_pkg::OP_ADD) used_ids = {used_ids, id};
    endtask

    function automatic logic [31:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 2) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom_range(0, 40) + 32'd1000;
    endfunction

    initial begin
        int burst;
        int gap;
        logic [1:0] o;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: rest, cross, partial fill, extremes, errors
        send(lob_pkg::OP_ADD, 32'd1, 1'b1, 32'd100, 32'd10);
        send(lob_pkg::OP_ADD, 32'd2, 1'b1, 32'd100, 32'd5);
        send(lob_pkg::OP_ADD, 32'd3, 1'b0, 32'd101, 32'd12);
        send(lob_pkg::OP_ADD, 32'd4, 1'b0, 32'd99, 32'd0);
        send(lob_pkg::OP_ADD, 32'd3, 1'b0, 32'd50, 32'd1);
        send(lob_pkg::OP_CANCEL, 32'd77, 1'b0, 32'd0, 32'd0);
        send(lob_pkg::OP_MODIFY, 32'd77, 1'b0, 32'd5, 32'd5);
        send(lob_pkg::OP_MODIFY, 32'd2, 1'b0, 32'd90, 32'd7);
        send(lob_pkg::OP_MODIFY, 32'd2, 1'b1, 32'd90, 32'd0);
        send(lob_pkg::OP_CANCEL, 32'd3, 1'b0, 32'd0, 32'd0);
        send(lob_pkg::OP_NOP, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(lob_pkg::OP_ADD, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(lob_pkg::OP_ADD, 32'd0, 1'b1, 32'd0, 32'hFFFFFFFF);
        // fill the book for book_full, then sweep it with one large order
        for (int i = 0; i < 64; i++)
            send(lob_pkg::OP_ADD, 32'd5000 + 32'(i), 1'b1, 32'd200 + 32'(i), 32'd1);
        send(lob_pkg::OP_ADD, 32'd6000, 1'b0, 32'd1, 32'd1);
        send(lob_pkg::OP_ADD, 32'd6001, 1'b0, 32'hFFFFFFF0, 32'd100);
        send(lob_pkg::OP_CANCEL, 32'd6001, 1'b0, 32'd0, 32'd0);
        send(lob_pkg::OP_CANCEL, 32'd0, 1'b0, 32'd0, 32'd0);
        // random: mostly clustered prices for crossing, bursts with gaps
        for (int n = 0; n < 380; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                if ($urandom_range(0, 9) < 6) o = lob_pkg::OP_ADD;
                else o = 2'($urandom_range(1, 3));
                if ($urandom_range(0, 15) == 0)
                    send(o, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    send(o, pick_id(), 1'($urandom_range(0, 1)),
                         32'($urandom_range(90, 110)), 32'($urandom_range(0, 20)));
                n++;
            end
            gap = $urandom_range(0, 300);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (errors == 0 && pending == 0) $display("limit_order_book_matcher test passed");
        else $display("limit_order_book_matcher test failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/lob_pkg.sv
sv/lob_cell.sv
sv/limit_order_book_matcher.sv
verif/limit_order_book_matcher_checker.sv
verif/limit_order_book_matcher_tb.sv
